// ===== hdl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and codes of the triangle primitive assembly block.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int IDX_W  = 32;
	localparam int HDL_W  = 16;
	localparam int SLOT_W = IDX_W + HDL_W;
	localparam int ID_W   = 32;
	localparam int RC_W   = 40;
	localparam int VC_W   = 24;
	localparam int IC_W   = 16;
	localparam int CFG_W  = 24;
	localparam int NRD    = 6;

	localparam logic [2:0] MODE_LIST   = 3'd0;
	localparam logic [2:0] MODE_STRIP  = 3'd1;
	localparam logic [2:0] MODE_FAN    = 3'd2;
	localparam logic [2:0] MODE_QUAD   = 3'd3;
	localparam logic [2:0] MODE_QSTRIP = 3'd4;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_VCOUNT = 2'd1;
	localparam logic [1:0] REG_ICOUNT = 2'd2;

	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	// what one accepted item leaves for the result stage
	typedef struct packed {
		logic [1:0]       tri_vld;
		logic             end_vld;
		logic [ID_W-1:0]  tri_id;
		logic [ID_W-1:0]  end_id;
		logic [NRD-1:0]   fwd_hit;
		logic [IDX_W-1:0] fwd_index;
		logic [HDL_W-1:0] fwd_handle;
	} pat_run_t;

	typedef struct packed {
		logic                  is_end;
		logic [ID_W-1:0]       tri_id;
		logic [2:0][IDX_W-1:0] idx;
		logic [2:0][HDL_W-1:0] hdl;
		logic                  last;
	} pat_res_t;

endpackage

// ===== hdl/primitive_assembly_triangles_core.sv =====
// ----------------------------------------------------------------------------
// primitive_assembly_triangles_core
// Assembles triangles from a vertex stream in list, strip, fan, quad and
// quad strip modes, drops degenerate triangles and marks the end of a batch.
//
//   channel   signals                                 transfer when
//   input     in_valid in_ready kind vertex_index ..  in_valid && in_ready
//   output    out_valid out_ready is_end tri_id ..    out_valid && out_ready
//   config    cfg_we cfg_addr cfg_wdata               cfg_we
//
// An item is taken every cycle while the result buffer drains in time; the
// output gives one result a cycle while out_ready is high, so an item with k
// results holds it until all k are transferred. An accepted item is registered
// in the slot read ports and stage one, then moves into the result buffer once
// that is free. Reset clears counters and pointers; slot memory is not cleared.
// A stalled output holds the buffer, and the input stalls once the result stage is full.
// ----------------------------------------------------------------------------
module primitive_assembly_triangles_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [pat_pkg::IDX_W-1:0]     vertex_index,
	input  logic [pat_pkg::HDL_W-1:0]     attr_handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_end,
	output logic [pat_pkg::ID_W-1:0]      tri_id,
	output logic [pat_pkg::IDX_W-1:0]     first_index,
	output logic [pat_pkg::IDX_W-1:0]     second_index,
	output logic [pat_pkg::IDX_W-1:0]     third_index,
	output logic [pat_pkg::HDL_W-1:0]     first_handle,
	output logic [pat_pkg::HDL_W-1:0]     second_handle,
	output logic [pat_pkg::HDL_W-1:0]     third_handle,
	output logic                          last_of_run,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [pat_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic                                         acc;
	logic                                         wr_en;
	logic [AW-1:0]                                wr_addr;
	logic [pat_pkg::NRD-1:0][AW-1:0]              rd_addr;
	logic [pat_pkg::NRD-1:0][pat_pkg::SLOT_W-1:0] rdata;
	pat_pkg::pat_run_t                            run;
	pat_pkg::pat_res_t                            res;

	assign acc = in_valid && in_ready;

	pat_ctrl #(.QD(QUEUE_DEPTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.kind        (kind),
		.vertex_index(vertex_index),
		.attr_handle (attr_handle),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.run         (run)
	);

	// three copies of the slot store give six corner reads per item
	for (genvar g = 0; g < 3; g++) begin : g_bank
		pat_ram #(.DEPTH(QUEUE_DEPTH), .W(pat_pkg::SLOT_W)) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (wr_addr),
			.wdata ({vertex_index, attr_handle}),
			.re    (acc),
			.raddr0(rd_addr[2*g]),
			.raddr1(rd_addr[2*g+1]),
			.rdata0(rdata[2*g]),
			.rdata1(rdata[2*g+1])
		);
	end

	pat_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.run      (run),
		.rdata    (rdata),
		.out_ready(out_ready),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.res      (res)
	);

	assign is_end        = res.is_end;
	assign tri_id        = res.tri_id;
	assign first_index   = res.idx[2];
	assign second_index  = res.idx[1];
	assign third_index   = res.idx[0];
	assign first_handle  = res.hdl[2];
	assign second_handle = res.hdl[1];
	assign third_handle  = res.hdl[0];
	assign last_of_run   = res.last;

endmodule

// ===== hdl/pat_ram.sv =====
// ----------------------------------------------------------------------------
// pat_ram
// Vertex slot memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pat_ram #(
	parameter int DEPTH = 16,
	parameter int W = 48,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [W-1:0]  rdata0,
	output logic [W-1:0]  rdata1
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== hdl/pat_ctrl.sv =====
// ----------------------------------------------------------------------------
// pat_ctrl
// Configuration registers, queue pointers and counters; works out the
// triangles of one item and the slot addresses of their corners.
// ----------------------------------------------------------------------------
module pat_ctrl #(
	parameter int QD = 16,
	localparam int AW = $clog2(QD),
	localparam int AW1 = AW + 1,
	localparam int CW = $clog2(QD + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            acc,
	input  logic                            kind,
	input  logic [pat_pkg::IDX_W-1:0]       vertex_index,
	input  logic [pat_pkg::HDL_W-1:0]       attr_handle,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_addr,
	input  logic [pat_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                            wr_en,
	output logic [AW-1:0]                   wr_addr,
	output logic [pat_pkg::NRD-1:0][AW-1:0] rd_addr,
	output pat_pkg::pat_run_t               run
);

	typedef struct packed {
		logic          ok;
		logic [CW-1:0] sc;
		logic [AW-1:0] ns;
		logic          odd;
		logic [AW-1:0] a;
		logic [AW-1:0] b;
		logic [AW-1:0] c;
	} step_t;

	logic [2:0]                  mode_q;
	logic [pat_pkg::VC_W-1:0]    vc_q;
	logic [pat_pkg::IC_W-1:0]    ic_q;
	logic [pat_pkg::RC_W-1:0]    total_q;
	logic [CW-1:0]               sc_q;
	logic [pat_pkg::RC_W-1:0]    rc_q;
	logic [AW-1:0]               ws_q;
	logic [AW-1:0]               ns_q;
	logic                        odd_q;
	logic [pat_pkg::ID_W-1:0]    tc_q;
	logic                        fin_q;

	logic [2:0]               em;
	logic                     quad;
	logic [CW-1:0]            need;
	logic                     is_vtx;
	logic                     do_step;
	logic                     upd;
	logic [CW-1:0]            sc0;
	logic [AW-1:0]            ns0;
	logic                     odd0;
	logic [pat_pkg::RC_W-1:0] rc_n;
	logic [AW-1:0]            ws_n;
	logic [pat_pkg::ID_W-1:0] tc0;
	step_t                    st1;
	step_t                    st2;
	logic [1:0]               tv;
	logic [CW-1:0]            sc_f;
	logic [AW-1:0]            ns_f;
	logic                     odd_f;
	logic [pat_pkg::ID_W-1:0] tc_f;
	logic                     end_vld;
	logic                     fin_f;

	function automatic logic [AW-1:0] bck(input logic [AW-1:0] s, input logic [2:0] k);
		logic [AW1-1:0] t;
		t = {1'b0, s};
		if (t >= AW1'(k)) begin
			return AW'(t - AW1'(k));
		end
		return AW'(t + AW1'(QD) - AW1'(k));
	endfunction

	function automatic logic [AW-1:0] fwd(input logic [AW-1:0] s, input logic [2:0] k);
		logic [AW1-1:0] t;
		t = {1'b0, s} + AW1'(k);
		if (t >= AW1'(QD)) begin
			t = t - AW1'(QD);
		end
		return t[AW-1:0];
	endfunction

	function automatic step_t asm_step(input logic [2:0] m, input logic [CW-1:0] sc,
			input logic [AW-1:0] ns, input logic odd);
		step_t r;
		logic [CW-1:0] nd;
		nd = (m == pat_pkg::MODE_QUAD || m == pat_pkg::MODE_QSTRIP) ? CW'(4) : CW'(3);
		r.ok = (sc >= nd);
		r.sc = sc;
		r.ns = ns;
		r.odd = odd;
		r.a = ns;
		r.b = ns;
		r.c = ns;
		case (m)
			pat_pkg::MODE_STRIP: begin
				r.sc = sc - CW'(1);
				if (odd) begin
					r.a = bck(ns, 3'd2);
					r.b = bck(ns, 3'd1);
					r.odd = 1'b0;
				end else begin
					r.a = bck(ns, 3'd1);
					r.b = bck(ns, 3'd2);
					r.odd = 1'b1;
				end
				r.ns = fwd(ns, 3'd1);
			end
			pat_pkg::MODE_FAN: begin
				r.sc = sc - CW'(1);
				r.a = '0;
				r.b = (ns == AW'(1)) ? AW'(QD - 1) : bck(ns, 3'd1);
				r.ns = (ns == AW'(QD - 1)) ? AW'(1) : fwd(ns, 3'd1);
			end
			pat_pkg::MODE_QUAD: begin
				if (odd) begin
					r.a = bck(ns, 3'd3);
					r.b = bck(ns, 3'd2);
					r.odd = 1'b0;
				end else begin
					r.sc = sc - CW'(4);
					r.a = bck(ns, 3'd2);
					r.b = bck(ns, 3'd1);
					r.odd = 1'b1;
					r.ns = fwd(ns, 3'd4);
				end
			end
			pat_pkg::MODE_QSTRIP: begin
				if (odd) begin
					r.a = bck(ns, 3'd3);
					r.b = bck(ns, 3'd2);
					r.odd = 1'b0;
				end else begin
					r.sc = sc - CW'(2);
					r.a = bck(ns, 3'd1);
					r.b = bck(ns, 3'd3);
					r.odd = 1'b1;
					r.ns = fwd(ns, 3'd2);
				end
			end
			default: begin
				r.sc = sc - CW'(3);
				r.a = bck(ns, 3'd2);
				r.b = bck(ns, 3'd1);
				r.ns = fwd(ns, 3'd3);
			end
		endcase
		if (!r.ok) begin
			r.sc = sc;
			r.ns = ns;
			r.odd = odd;
		end
		return r;
	endfunction

	always_comb begin
		em = (mode_q <= pat_pkg::MODE_QSTRIP) ? mode_q : pat_pkg::MODE_LIST;
		quad = (em == pat_pkg::MODE_QUAD) || (em == pat_pkg::MODE_QSTRIP);
		need = quad ? CW'(4) : CW'(3);
		is_vtx = (kind == pat_pkg::KIND_VERTEX);
		do_step = is_vtx && !fin_q;
		upd = acc && (!is_vtx || !fin_q);

		if (is_vtx) begin
			sc0 = (sc_q < CW'(QD)) ? sc_q + CW'(1) : sc_q;
			ns0 = ns_q;
			odd0 = odd_q;
			rc_n = rc_q + pat_pkg::RC_W'(1);
			tc0 = tc_q;
			if (em == pat_pkg::MODE_FAN && ws_q == AW'(QD - 1)) begin
				ws_n = AW'(1);
			end else begin
				ws_n = fwd(ws_q, 3'd1);
			end
		end else begin
			sc0 = '0;
			ns0 = quad ? AW'(3) : AW'(2);
			odd0 = 1'b1;
			rc_n = '0;
			tc0 = '0;
			ws_n = '0;
		end

		st1 = asm_step(em, sc0, ns0, odd0);
		st2 = asm_step(em, st1.sc, st1.ns, st1.odd);
		tv[0] = do_step && st1.ok;
		tv[1] = do_step && st1.ok && st2.ok;

		if (tv[1]) begin
			sc_f = st2.sc;
			ns_f = st2.ns;
			odd_f = st2.odd;
			tc_f = tc0 + pat_pkg::ID_W'(2);
		end else if (tv[0]) begin
			sc_f = st1.sc;
			ns_f = st1.ns;
			odd_f = st1.odd;
			tc_f = tc0 + pat_pkg::ID_W'(1);
		end else begin
			sc_f = sc0;
			ns_f = ns0;
			odd_f = odd0;
			tc_f = tc0;
		end

		end_vld = (!is_vtx || !fin_q) && (rc_n == total_q) && (sc_f < need);
		fin_f = end_vld || (is_vtx && fin_q);

		wr_en = acc && do_step;
		wr_addr = ws_q;
		rd_addr[0] = st1.a;
		rd_addr[1] = st1.b;
		rd_addr[2] = st1.c;
		rd_addr[3] = st2.a;
		rd_addr[4] = st2.b;
		rd_addr[5] = st2.c;

		run.tri_vld = tv;
		run.end_vld = end_vld;
		run.tri_id = tc0;
		run.end_id = tc_f;
		for (int k = 0; k < pat_pkg::NRD; k++) begin
			run.fwd_hit[k] = do_step && (rd_addr[k] == ws_q);
		end
		run.fwd_index = vertex_index;
		run.fwd_handle = attr_handle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pat_pkg::MODE_LIST;
			vc_q <= '0;
			ic_q <= pat_pkg::IC_W'(1);
			total_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				pat_pkg::REG_MODE: begin
					mode_q <= cfg_wdata[2:0];
				end
				pat_pkg::REG_VCOUNT: begin
					vc_q <= cfg_wdata[pat_pkg::VC_W-1:0];
					total_q <= pat_pkg::RC_W'(cfg_wdata[pat_pkg::VC_W-1:0])
						* pat_pkg::RC_W'(ic_q);
				end
				pat_pkg::REG_ICOUNT: begin
					ic_q <= cfg_wdata[pat_pkg::IC_W-1:0];
					total_q <= pat_pkg::RC_W'(vc_q)
						* pat_pkg::RC_W'(cfg_wdata[pat_pkg::IC_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
			rc_q <= '0;
			ws_q <= '0;
			ns_q <= '0;
			odd_q <= 1'b1;
			tc_q <= '0;
			fin_q <= 1'b0;
		end else if (upd) begin
			sc_q <= sc_f;
			rc_q <= rc_n;
			ws_q <= ws_n;
			ns_q <= ns_f;
			odd_q <= odd_f;
			tc_q <= tc_f;
			fin_q <= fin_f;
		end
	end

endmodule

// ===== hdl/pat_out.sv =====
// ----------------------------------------------------------------------------
// pat_out
// Result stage: gathers corner data, drops degenerate triangles and queues
// up to three results of one item for the output channel.
// ----------------------------------------------------------------------------
module pat_out (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      acc,
	input  pat_pkg::pat_run_t                         run,
	input  logic [pat_pkg::NRD-1:0][pat_pkg::SLOT_W-1:0] rdata,
	input  logic                                      out_ready,
	output logic                                      in_ready,
	output logic                                      out_valid,
	output pat_pkg::pat_res_t                         res
);

	logic              vld_s1;
	pat_pkg::pat_run_t run_s1;

	pat_pkg::pat_res_t ent_q [3];
	logic [1:0]        n_q;
	logic [1:0]        head_q;

	logic [pat_pkg::SLOT_W-1:0] slot;
	pat_pkg::pat_res_t          tr [2];
	pat_pkg::pat_res_t          endr;
	pat_pkg::pat_res_t          lst [3];
	logic [1:0]                 emit;
	logic [1:0]                 n_new;
	logic                       last_xfer;
	logic                       s2_free;
	logic                       move;

	always_comb begin
		slot = '0;
		for (int t = 0; t < 2; t++) begin
			tr[t].is_end = 1'b0;
			tr[t].tri_id = run_s1.tri_id + pat_pkg::ID_W'(t);
			tr[t].last = 1'b0;
			for (int j = 0; j < 3; j++) begin
				slot = run_s1.fwd_hit[3*t+j] ? {run_s1.fwd_index, run_s1.fwd_handle}
					: rdata[3*t+j];
				tr[t].idx[2-j] = slot[pat_pkg::SLOT_W-1:pat_pkg::HDL_W];
				tr[t].hdl[2-j] = slot[pat_pkg::HDL_W-1:0];
			end
			emit[t] = run_s1.tri_vld[t] && !(tr[t].idx[2] == tr[t].idx[1] ||
				tr[t].idx[1] == tr[t].idx[0] || tr[t].idx[0] == tr[t].idx[2]);
		end

		endr = '0;
		endr.is_end = 1'b1;
		endr.tri_id = run_s1.end_id;

		lst[0] = emit[0] ? tr[0] : (emit[1] ? tr[1] : endr);
		lst[1] = (emit[0] && emit[1]) ? tr[1] : endr;
		lst[2] = endr;
		n_new = 2'(emit[0]) + 2'(emit[1]) + 2'(run_s1.end_vld);
		for (int i = 0; i < 3; i++) begin
			lst[i].last = (2'(i + 1) == n_new);
		end

		out_valid = (head_q != n_q);
		res = ent_q[head_q];
		last_xfer = out_valid && out_ready && (head_q + 2'd1 == n_q);
		s2_free = (n_q == 2'd0) || last_xfer;
		move = vld_s1 && s2_free;
		in_ready = !vld_s1 || move;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			run_s1 <= run;
		end
		if (move) begin
			for (int i = 0; i < 3; i++) begin
				ent_q[i] <= lst[i];
			end
		end
	end

	// result buffer pointers, cleared once the last result is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			head_q <= '0;
		end else if (move) begin
			n_q <= n_new;
			head_q <= '0;
		end else if (last_xfer) begin
			n_q <= '0;
			head_q <= '0;
		end else if (out_valid && out_ready) begin
			head_q <= head_q + 2'd1;
		end
	end

endmodule

// ===== hdl/pat_chk.sv =====
// ----------------------------------------------------------------------------
// pat_chk
// Port-level checks of the triangle primitive assembly block.
// ----------------------------------------------------------------------------
module pat_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      is_end,
	input logic [pat_pkg::ID_W-1:0]  tri_id,
	input logic [pat_pkg::IDX_W-1:0] first_index,
	input logic [pat_pkg::IDX_W-1:0] second_index,
	input logic [pat_pkg::IDX_W-1:0] third_index,
	input logic [pat_pkg::HDL_W-1:0] first_handle,
	input logic [pat_pkg::HDL_W-1:0] second_handle,
	input logic [pat_pkg::HDL_W-1:0] third_handle,
	input logic                      last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tri_id) && $stable(is_end)
			&& $stable(first_index) && $stable(last_of_run))
		else $error("stalled result changed");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> last_of_run && first_index == 0 && second_index == 0
			&& third_index == 0 && first_handle == 0 && second_handle == 0
			&& third_handle == 0)
		else $error("end marker carries corner data or is not last");

	a_no_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> first_index != second_index
			&& second_index != third_index && third_index != first_index)
		else $error("degenerate triangle sent");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run of results");

endmodule

bind primitive_assembly_triangles_core pat_chk u_pat_chk (.*);

// ===== bench/tri_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// tri_sb_pkg
// Scoreboard for the triangle primitive assembly block. It keeps its own copy
// of the vertex queue, counters and registers, predicts the triangles and end
// markers of every accepted transfer, and checks the results in order.
// ----------------------------------------------------------------------------
package tri_sb_pkg;

	localparam int QDEPTH = 16;

	class tri_scoreboard;
		logic [2:0]                mode_reg;
		logic [pat_pkg::VC_W-1:0]  vcount_reg;
		logic [pat_pkg::IC_W-1:0]  icount_reg;
		logic [pat_pkg::IDX_W-1:0] slot_idx [QDEPTH];
		logic [pat_pkg::HDL_W-1:0] slot_hdl [QDEPTH];
		int unsigned               held;
		logic [pat_pkg::RC_W-1:0]  arrived;
		int unsigned               wr_slot;
		int unsigned               newest;
		bit                        odd;
		logic [pat_pkg::ID_W-1:0]  tri_ctr;
		bit                        done;
		pat_pkg::pat_res_t         expected_tris [$];
		int                        mismatches;

		function new();
			mode_reg = pat_pkg::MODE_LIST;
			vcount_reg = '0;
			icount_reg = pat_pkg::IC_W'(1);
			clear_draw();
			newest = 0;
			mismatches = 0;
		endfunction

		function void clear_draw();
			foreach (slot_idx[i]) begin
				slot_idx[i] = '0;
				slot_hdl[i] = '0;
			end
			held = 0;
			arrived = '0;
			wr_slot = 0;
			odd = 1'b1;
			tri_ctr = '0;
			done = 1'b0;
		endfunction

		function logic [2:0] cur_mode();
			return (mode_reg <= pat_pkg::MODE_QSTRIP) ? mode_reg : pat_pkg::MODE_LIST;
		endfunction

		function int unsigned corners_needed();
			logic [2:0] m;
			m = cur_mode();
			return (m == pat_pkg::MODE_QUAD || m == pat_pkg::MODE_QSTRIP) ? 4 : 3;
		endfunction

		function int unsigned back(int unsigned s, int unsigned k);
			return (s + QDEPTH - k) % QDEPTH;
		endfunction

		function void note_config(logic [1:0] addr, logic [pat_pkg::CFG_W-1:0] data);
			case (addr)
				pat_pkg::REG_MODE: mode_reg = data[2:0];
				pat_pkg::REG_VCOUNT: vcount_reg = data[pat_pkg::VC_W-1:0];
				pat_pkg::REG_ICOUNT: icount_reg = data[pat_pkg::IC_W-1:0];
				default: ;
			endcase
		endfunction

		// 0 nothing to build, 1 degenerate dropped, 2 triangle built
		function int build_tri(output pat_pkg::pat_res_t t);
			logic [2:0] m;
			int unsigned a, b, c, ns;
			m = cur_mode();
			ns = newest % QDEPTH;
			t = '0;
			if (held < corners_needed())
				return 0;
			c = ns;
			case (m)
				pat_pkg::MODE_STRIP: begin
					held -= 1;
					if (odd) begin
						a = back(ns, 2);
						b = back(ns, 1);
					end else begin
						a = back(ns, 1);
						b = back(ns, 2);
					end
					odd = !odd;
					newest = (ns + 1) % QDEPTH;
				end
				pat_pkg::MODE_FAN: begin
					held -= 1;
					a = 0;
					b = (ns == 1) ? QDEPTH - 1 : back(ns, 1);
					newest = (ns == QDEPTH - 1) ? 1 : (ns + 1) % QDEPTH;
				end
				pat_pkg::MODE_QUAD: begin
					if (odd) begin
						a = back(ns, 3);
						b = back(ns, 2);
						odd = 1'b0;
					end else begin
						held -= 4;
						a = back(ns, 2);
						b = back(ns, 1);
						odd = 1'b1;
						newest = (ns + 4) % QDEPTH;
					end
				end
				pat_pkg::MODE_QSTRIP: begin
					if (odd) begin
						a = back(ns, 3);
						b = back(ns, 2);
						odd = 1'b0;
					end else begin
						held -= 2;
						a = back(ns, 1);
						b = back(ns, 3);
						odd = 1'b1;
						newest = (ns + 2) % QDEPTH;
					end
				end
				default: begin
					held -= 3;
					a = back(ns, 2);
					b = back(ns, 1);
					newest = (ns + 3) % QDEPTH;
				end
			endcase
			if (slot_idx[a] == slot_idx[b] || slot_idx[b] == slot_idx[c] ||
			    slot_idx[c] == slot_idx[a]) begin
				tri_ctr += 1;
				return 1;
			end
			t.is_end = 1'b0;
			t.tri_id = tri_ctr;
			t.idx[0] = slot_idx[a];
			t.idx[1] = slot_idx[b];
			t.idx[2] = slot_idx[c];
			t.hdl[0] = slot_hdl[a];
			t.hdl[1] = slot_hdl[b];
			t.hdl[2] = slot_hdl[c];
			t.last = 1'b0;
			tri_ctr += 1;
			return 2;
		endfunction

		// returns 0 when a vertex arrives after the end marker and is ignored
		function bit note_input(logic kind, logic [pat_pkg::IDX_W-1:0] vidx,
			logic [pat_pkg::HDL_W-1:0] ahdl);
			pat_pkg::pat_res_t run [$];
			pat_pkg::pat_res_t t;
			int                r;
			logic [63:0]       total;
			logic [2:0]        m;
			if (kind == pat_pkg::KIND_START) begin
				m = cur_mode();
				clear_draw();
				newest = (m == pat_pkg::MODE_QUAD || m == pat_pkg::MODE_QSTRIP) ? 3 : 2;
			end else begin
				if (done)
					return 1'b0;
				slot_idx[wr_slot] = vidx;
				slot_hdl[wr_slot] = ahdl;
				if (held < QDEPTH)
					held += 1;
				arrived += 1;
				if (cur_mode() == pat_pkg::MODE_FAN)
					wr_slot = (wr_slot == QDEPTH - 1) ? 1 : wr_slot + 1;
				else
					wr_slot = (wr_slot + 1) % QDEPTH;
				for (int i = 0; i < 2; i++) begin
					r = build_tri(t);
					if (r == 0)
						break;
					if (r == 2)
						run.push_back(t);
				end
			end
			total = 64'(vcount_reg) * 64'(icount_reg);
			if (!done && 64'(arrived) == total && held < corners_needed()) begin
				t = '0;
				t.is_end = 1'b1;
				t.tri_id = tri_ctr;
				done = 1'b1;
				run.push_back(t);
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				expected_tris.push_back(run[i]);
			return 1'b1;
		endfunction

		function void show(string tag, pat_pkg::pat_res_t r);
			$display("  %s end=%0d id=%h idx=%h/%h/%h hdl=%h/%h/%h last=%0d", tag, r.is_end,
				r.tri_id, r.idx[0], r.idx[1], r.idx[2], r.hdl[0], r.hdl[1], r.hdl[2], r.last);
		endfunction

		function void check_result(pat_pkg::pat_res_t got);
			pat_pkg::pat_res_t want;
			bit                bad;
			if (expected_tris.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with nothing expected");
					show("actual  ", got);
				end
				return;
			end
			want = expected_tris.pop_front();
			bad = (got.is_end !== want.is_end) || (got.tri_id !== want.tri_id) ||
				(got.last !== want.last);
			for (int k = 0; k < 3; k++)
				bad |= (got.idx[k] !== want.idx[k]) || (got.hdl[k] !== want.hdl[k]);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch");
					show("expected", want);
					show("actual  ", got);
				end
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives vertex and start-draw transfers into the triangle primitive assembly
// core across all primitive modes and draw sizes, with random gaps on the
// input and random stalls on the output, and checks every triangle and end
// marker against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      kind = pat_pkg::KIND_START;
	logic [pat_pkg::IDX_W-1:0] vertex_index = '0;
	logic [pat_pkg::HDL_W-1:0] attr_handle = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      is_end;
	logic [pat_pkg::ID_W-1:0]  tri_id;
	logic [pat_pkg::IDX_W-1:0] first_index, second_index, third_index;
	logic [pat_pkg::HDL_W-1:0] first_handle, second_handle, third_handle;
	logic                      last_of_run;
	logic                      cfg_we = 1'b0;
	logic [1:0]                cfg_addr = pat_pkg::REG_MODE;
	logic [pat_pkg::CFG_W-1:0] cfg_wdata = '0;

	tri_sb_pkg::tri_scoreboard sb;
	int                        send_idle_pct = 0;
	int                        recv_stall_pct = 0;
	int                        draw_items = 0;
	logic [pat_pkg::IDX_W-1:0] pool_base = '0;

	primitive_assembly_triangles_core #(.QUEUE_DEPTH(tri_sb_pkg::QDEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.vertex_index(vertex_index), .attr_handle(attr_handle),
		.out_valid(out_valid), .out_ready(out_ready), .is_end(is_end), .tri_id(tri_id),
		.first_index(first_index), .second_index(second_index), .third_index(third_index),
		.first_handle(first_handle), .second_handle(second_handle),
		.third_handle(third_handle), .last_of_run(last_of_run),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// values are settled at the falling edge and taken at the next rising edge
	always @(negedge clk) begin
		pat_pkg::pat_res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.is_end = is_end;
			got.tri_id = tri_id;
			got.idx[0] = first_index;
			got.idx[1] = second_index;
			got.idx[2] = third_index;
			got.hdl[0] = first_handle;
			got.hdl[1] = second_handle;
			got.hdl[2] = third_handle;
			got.last = last_of_run;
			sb.check_result(got);
		end
	end

	task automatic send(input logic k, input logic [pat_pkg::IDX_W-1:0] vi,
		input logic [pat_pkg::HDL_W-1:0] ah);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		vertex_index <= vi;
		attr_handle <= ah;
		do @(negedge clk); while (!in_ready);
		if (sb.note_input(k, vi, ah))
			draw_items++;
		@(posedge clk);
	endtask

	task automatic vertex(input logic [pat_pkg::IDX_W-1:0] vi);
		send(pat_pkg::KIND_VERTEX, vi, pat_pkg::HDL_W'($urandom_range(0, 65535)));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_tris.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] a, input logic [pat_pkg::CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		sb.note_config(a, d);
		@(posedge clk);
	endtask

	task automatic configure(input logic [2:0] m, input logic [pat_pkg::VC_W-1:0] vc,
		input logic [pat_pkg::IC_W-1:0] ic);
		cfg_write(pat_pkg::REG_MODE, pat_pkg::CFG_W'(m));
		cfg_write(pat_pkg::REG_VCOUNT, pat_pkg::CFG_W'(vc));
		cfg_write(pat_pkg::REG_ICOUNT, pat_pkg::CFG_W'(ic));
		cfg_we <= 1'b0;
	endtask

	// a small pool of indices makes degenerate triangles common
	function automatic logic [pat_pkg::IDX_W-1:0] rand_index();
		if ($urandom_range(0, 3) == 0)
			return pool_base + pat_pkg::IDX_W'($urandom_range(0, 2));
		return pat_pkg::IDX_W'($urandom());
	endfunction

	task automatic random_draw(input int phase_no);
		logic [2:0]               m;
		logic [pat_pkg::VC_W-1:0] vc;
		logic [pat_pkg::IC_W-1:0] ic;
		logic [63:0]              total;
		int                       sel, variant, nvert, cut;
		case (phase_no % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 73; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 73; end
			default: begin send_idle_pct = 35; recv_stall_pct = 35; end
		endcase
		if ($urandom_range(0, 5) == 0)
			m = pat_pkg::MODE_QSTRIP + 3'($urandom_range(1, 3));
		else
			m = 3'($urandom_range(0, 4));
		sel = $urandom_range(0, 15);
		case (sel)
			0: begin
				vc = '0;
				ic = $urandom_range(0, 1) ? 16'hFFFF : pat_pkg::IC_W'($urandom());
			end
			1: begin
				vc = 24'hFF_FFFF;
				ic = 16'hFFFF;
			end
			2: begin
				vc = pat_pkg::VC_W'($urandom_range(1, 8));
				ic = '0;
			end
			default: begin
				vc = pat_pkg::VC_W'($urandom_range(1, 12));
				ic = pat_pkg::IC_W'($urandom_range(1, 2));
			end
		endcase
		total = 64'(vc) * 64'(ic);
		nvert = (total > 24) ? $urandom_range(3, 12) : int'(total);
		configure(m, vc, ic);
		pool_base = pat_pkg::IDX_W'($urandom());
		send(pat_pkg::KIND_START, pat_pkg::IDX_W'($urandom()), pat_pkg::HDL_W'($urandom()));
		variant = $urandom_range(0, 9);
		if (variant == 0 && nvert > 1)
			nvert = $urandom_range(1, nvert - 1);
		if (variant == 2 && nvert >= 2 && total <= 24) begin
			// shrink the batch below what has arrived: the rest is assembled, no end
			cut = $urandom_range(1, nvert - 1);
			repeat (cut) vertex(rand_index());
			settle();
			cfg_write(pat_pkg::REG_VCOUNT, '0);
			cfg_we <= 1'b0;
			repeat ($urandom_range(3, 8)) vertex(rand_index());
		end else begin
			repeat (nvert) vertex(rand_index());
			if (variant == 1)
				repeat ($urandom_range(1, 3)) vertex(rand_index());
		end
		settle();
	endtask

	initial begin
		int phase_no;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// vertices before any draw, then an empty draw and a vertex after its end
		send(pat_pkg::KIND_VERTEX, 32'h0000_0000, 16'h0000);
		send(pat_pkg::KIND_VERTEX, 32'hFFFF_FFFF, 16'hFFFF);
		send(pat_pkg::KIND_START, '0, '0);
		send(pat_pkg::KIND_VERTEX, 32'h1234_5678, 16'hBEEF);
		settle();

		configure(pat_pkg::MODE_LIST, 24'd3, 16'd2);
		send(pat_pkg::KIND_START, '0, '0);
		send(pat_pkg::KIND_VERTEX, 32'h0000_0000, 16'h0000);
		send(pat_pkg::KIND_VERTEX, 32'hFFFF_FFFF, 16'hFFFF);
		send(pat_pkg::KIND_VERTEX, 32'h5555_AAAA, 16'h00FF);
		send(pat_pkg::KIND_VERTEX, 32'h0000_0007, 16'h0001);
		send(pat_pkg::KIND_VERTEX, 32'h0000_0007, 16'h0002);
		send(pat_pkg::KIND_VERTEX, 32'h0000_0009, 16'h0003);
		settle();

		configure(pat_pkg::MODE_STRIP, 24'd5, 16'd1);
		send(pat_pkg::KIND_START, '0, '0);
		send(pat_pkg::KIND_VERTEX, 32'd10, 16'h0A0A);
		send(pat_pkg::KIND_VERTEX, 32'd11, 16'h0B0B);
		send(pat_pkg::KIND_VERTEX, 32'd12, 16'h0C0C);
		send(pat_pkg::KIND_VERTEX, 32'd13, 16'h0D0D);
		send(pat_pkg::KIND_VERTEX, 32'd13, 16'h0E0E);
		settle();

		configure(pat_pkg::MODE_QUAD, 24'd4, 16'd1);
		send(pat_pkg::KIND_START, '0, '0);
		send(pat_pkg::KIND_VERTEX, 32'hAAAA_5555, 16'hF00F);
		send(pat_pkg::KIND_VERTEX, 32'h8000_0000, 16'h8000);
		send(pat_pkg::KIND_VERTEX, 32'h0000_0001, 16'h0001);
		send(pat_pkg::KIND_VERTEX, 32'h7FFF_FFFF, 16'h7FFF);
		settle();

		draw_items = 0;
		phase_no = 0;
		while (draw_items < 135) begin
			random_draw(phase_no);
			phase_no++;
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();

		if (sb.mismatches == 0 && sb.expected_tris.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
